>>> hdl/mwm_pkg.sv
// ----------------------------------------------------------------------------
// mwm_pkg
// shared widths and operation codes of the multiword integer multiplier
// ----------------------------------------------------------------------------
`default_nettype none

package mwm_pkg;

  localparam int WORD_W = 32;
  localparam int OP_W   = 2;
  localparam int LEN_W  = 6;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [LEN_W-1:0]  len_t;

  // operation codes of an input transfer; the remaining code is ignored
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A   = 2'd0,
    OP_LOAD_B   = 2'd1,
    OP_MULTIPLY = 2'd2
  } opcode_e;

endpackage

`default_nettype wire

>>> hdl/mwm_if.sv
// ----------------------------------------------------------------------------
// mwm_in_if / mwm_out_if
// valid/ready channels for operand and product words
// ----------------------------------------------------------------------------
`default_nettype none

interface mwm_in_if;
  logic          valid;
  logic          ready;
  mwm_pkg::op_t  opcode;
  mwm_pkg::word_t word_value;

  modport source (output valid, output opcode, output word_value, input ready);
  modport sink   (input valid, input opcode, input word_value, output ready);
endinterface

interface mwm_out_if;
  logic           valid;
  logic           ready;
  mwm_pkg::word_t product_word;
  logic           is_last;
  mwm_pkg::len_t  product_length;
  logic           is_empty;
  logic           overflow;

  modport source (output valid, output product_word, output is_last, output product_length,
                  output is_empty, output overflow, input ready);
  modport sink   (input valid, input product_word, input is_last, input product_length,
                  input is_empty, input overflow, output ready);
endinterface

`default_nettype wire

>>> hdl/mwm_mul.sv
// ----------------------------------------------------------------------------
// mwm_mul
// registered 32x32 unsigned multiplier shared by every word product
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_mul (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire mwm_pkg::word_t             a_i,
  input  wire mwm_pkg::word_t             b_i,
  output logic [2*mwm_pkg::WORD_W-1:0]    p_o
);
  import mwm_pkg::*;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= {{WORD_W{1'b0}}, a_i} * {{WORD_W{1'b0}}, b_i};
    end
  end

endmodule

`default_nettype wire

>>> hdl/multiword_integer_multiplier_unit.sv
// ----------------------------------------------------------------------------
// multiword_integer_multiplier_unit
// schoolbook multiprecision multiplier on little-endian 32-bit words
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                           transfer
//  -------  ---  ------------------------------------------------  -----------------
//  in_i     in   opcode, word_value                                valid & ready
//  res_o    out  product_word, is_last, product_length, is_empty,  valid & ready
//                overflow
//
//  a load transfer leaves the unit idle, so in_i.ready stays high
//  a multiply does read, multiply, add per word pair and a carry store per row
//  on the one shared multiplier and the accumulator, then shows each product word
//  an empty operand gives a single result, valid from the edge of the transfer
//  and taken at the earliest in the cycle after the transfer
//  in_i.ready is low from a multiply transfer until its last result is taken
//  rst_ni clears counts, flag and control; the word stores need no clearing
// ----------------------------------------------------------------------------
`default_nettype none

module multiword_integer_multiplier_unit #(
  parameter int MAX_WORDS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mwm_in_if.sink     in_i,
  mwm_out_if.source  res_o
);
  import mwm_pkg::*;

  localparam int IdxW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CntW     = $clog2(MAX_WORDS + 1);
  localparam int AccDepth = 2 * MAX_WORDS;
  localparam int AccIdxW  = $clog2(AccDepth);
  localparam int AccCntW  = $clog2(AccDepth + 1);

  typedef enum logic [2:0] {
    S_IDLE,     // take loads and multiply transfers
    S_RD,       // read a[i], b[j] and acc[i+j]
    S_MUL,      // shared multiplier works on the read words
    S_ADD,      // add partial sum and carry, write acc[i+j]
    S_ROWEND,   // store row carry at acc[i+wb]
    S_ERD,      // read product word k
    S_ELOAD,    // load result register
    S_OUT       // wait for the result transfer
  } state_e;

  state_e state_q;

  // operand counts and flag
  logic [CntW-1:0]    a_cnt_q, b_cnt_q;
  logic               dropped_q;

  // loop counters of the schoolbook walk
  logic [CntW-1:0]    wa_q, wb_q, i_q, j_q;
  logic [AccCntW-1:0] wc_q, k_q;
  word_t              carry_q;
  logic               ovf_q;

  // memories and their registered read data
  word_t a_mem   [MAX_WORDS];
  word_t b_mem   [MAX_WORDS];
  word_t acc_mem [AccDepth];
  word_t a_rdata_q, b_rdata_q, acc_rdata_q;

  logic [2*WORD_W-1:0] prod;
  logic [2*WORD_W-1:0] sum_d;
  word_t               addend;

  logic               in_fire, res_fire;
  logic               a_we, b_we, ab_re, acc_re, acc_we;
  logic [AccIdxW-1:0] acc_raddr, acc_waddr;
  word_t              acc_wdata;

  // result register
  word_t out_word_q;
  logic  out_valid_q, out_last_q, out_empty_q, out_ovf_q;
  len_t  out_len_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign res_fire   = res_o.valid && res_o.ready;

  assign res_o.valid          = out_valid_q;
  assign res_o.product_word   = out_word_q;
  assign res_o.is_last        = out_last_q;
  assign res_o.product_length = out_len_q;
  assign res_o.is_empty       = out_empty_q;
  assign res_o.overflow       = out_ovf_q;

  // loads beyond capacity only raise the flag
  assign a_we = in_fire && (in_i.opcode == OP_LOAD_A) && (a_cnt_q != CntW'(MAX_WORDS));
  assign b_we = in_fire && (in_i.opcode == OP_LOAD_B) && (b_cnt_q != CntW'(MAX_WORDS));

  assign ab_re  = (state_q == S_RD);
  assign acc_re = (state_q == S_RD) || (state_q == S_ERD);

  always_comb begin
    if (state_q == S_ERD) begin
      acc_raddr = k_q[AccIdxW-1:0];
    end else begin
      acc_raddr = AccIdxW'(i_q) + AccIdxW'(j_q);
    end
  end

  // first row sees a cleared accumulator, later rows read what the row before left
  assign addend = (i_q == '0) ? '0 : acc_rdata_q;
  assign sum_d  = prod + {{WORD_W{1'b0}}, addend} + {{WORD_W{1'b0}}, carry_q};

  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = AccIdxW'(i_q) + AccIdxW'(j_q);
    acc_wdata = sum_d[WORD_W-1:0];
    case (state_q)
      S_ADD: begin
        acc_we = 1'b1;
      end
      S_ROWEND: begin
        acc_we    = 1'b1;
        acc_waddr = AccIdxW'(i_q) + AccIdxW'(wb_q);
        acc_wdata = carry_q;
      end
      default: begin
        acc_we = 1'b0;
      end
    endcase
  end

  // operand stores
  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[a_cnt_q[IdxW-1:0]] <= in_i.word_value;
    end
    if (b_we) begin
      b_mem[b_cnt_q[IdxW-1:0]] <= in_i.word_value;
    end
    if (ab_re) begin
      a_rdata_q <= a_mem[i_q[IdxW-1:0]];
      b_rdata_q <= b_mem[j_q[IdxW-1:0]];
    end
  end

  // product accumulator
  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (acc_re) begin
      acc_rdata_q <= acc_mem[acc_raddr];
    end
  end

  // the one shared word multiplier
  mwm_mul u_mul (
    .clk_i (clk_i),
    .en_i  (state_q == S_MUL),
    .a_i   (a_rdata_q),
    .b_i   (b_rdata_q),
    .p_o   (prod)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      a_cnt_q     <= '0;
      b_cnt_q     <= '0;
      dropped_q   <= 1'b0;
      wa_q        <= '0;
      wb_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      wc_q        <= '0;
      k_q         <= '0;
      carry_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_last_q  <= 1'b0;
      out_len_q   <= '0;
      out_empty_q <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            case (opcode_e'(in_i.opcode))
              OP_LOAD_A: begin
                if (a_we) begin
                  a_cnt_q <= a_cnt_q + CntW'(1);
                end else begin
                  dropped_q <= 1'b1;
                end
              end
              OP_LOAD_B: begin
                if (b_we) begin
                  b_cnt_q <= b_cnt_q + CntW'(1);
                end else begin
                  dropped_q <= 1'b1;
                end
              end
              OP_MULTIPLY: begin
                // counts and flag restart for the next operand pair
                a_cnt_q   <= '0;
                b_cnt_q   <= '0;
                dropped_q <= 1'b0;
                wa_q      <= a_cnt_q;
                wb_q      <= b_cnt_q;
                wc_q      <= AccCntW'(a_cnt_q) + AccCntW'(b_cnt_q);
                ovf_q     <= dropped_q;
                i_q       <= '0;
                j_q       <= '0;
                k_q       <= '0;
                carry_q   <= '0;
                if ((a_cnt_q == '0) || (b_cnt_q == '0)) begin
                  // empty operand: one zero result
                  out_valid_q <= 1'b1;
                  out_word_q  <= '0;
                  out_last_q  <= 1'b1;
                  out_len_q   <= '0;
                  out_empty_q <= 1'b1;
                  out_ovf_q   <= dropped_q;
                  state_q     <= S_OUT;
                end else begin
                  state_q <= S_RD;
                end
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_RD: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_ADD;
        end
        S_ADD: begin
          carry_q <= sum_d[2*WORD_W-1:WORD_W];
          if (j_q == wb_q - CntW'(1)) begin
            state_q <= S_ROWEND;
          end else begin
            j_q     <= j_q + CntW'(1);
            state_q <= S_RD;
          end
        end
        S_ROWEND: begin
          carry_q <= '0;
          j_q     <= '0;
          if (i_q == wa_q - CntW'(1)) begin
            state_q <= S_ERD;
          end else begin
            i_q     <= i_q + CntW'(1);
            state_q <= S_RD;
          end
        end
        S_ERD: begin
          state_q <= S_ELOAD;
        end
        S_ELOAD: begin
          out_valid_q <= 1'b1;
          out_word_q  <= acc_rdata_q;
          out_last_q  <= ((k_q + AccCntW'(1)) == wc_q);
          out_len_q   <= LEN_W'(wc_q);
          out_empty_q <= 1'b0;
          out_ovf_q   <= ovf_q;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (res_fire) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + AccCntW'(1);
              state_q <= S_ERD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/mwm_checker.sv
// ----------------------------------------------------------------------------
// mwm_checker
// port-level checks of the multiword multiplier, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_i,
  input wire logic           res_valid_i,
  input wire logic           res_ready_i,
  input wire mwm_pkg::word_t res_word_i,
  input wire logic           res_last_i,
  input wire mwm_pkg::len_t  res_len_i,
  input wire logic           res_empty_i,
  input wire logic           res_ovf_i
);
  import mwm_pkg::*;

  // a stalled result holds its payload
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_word_i)
      && $stable(res_last_i) && $stable(res_len_i) && $stable(res_ovf_i))
    else $error("stalled result changed");

  // no new item is taken while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && res_valid_i))
    else $error("input ready while a result is pending");

  // an empty product is a single zero word of length zero
  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_empty_i |-> res_last_i && (res_len_i == '0) && (res_word_i == '0))
    else $error("malformed empty result");

  // a real product has at least two words
  a_len_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_empty_i |-> (res_len_i >= LEN_W'(2)))
    else $error("product length too short");

  // after the last word the unit stops showing results
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && res_last_i |=> !res_valid_i)
    else $error("result shown after the last word");

endmodule

bind multiword_integer_multiplier_unit mwm_checker u_mwm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_word_i  (res_o.product_word),
  .res_last_i  (res_o.is_last),
  .res_len_i   (res_o.product_length),
  .res_empty_i (res_o.is_empty),
  .res_ovf_i   (res_o.overflow)
);

`default_nettype wire
